[sv/sbpm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbpm_pkg;

  localparam int ColW   = 6;
  localparam int MagW   = 8;
  localparam int LevelW = 6;
  localparam int RowW   = 7;
  localparam int CountW = 8;
  localparam int ColorW = 32;
  localparam int AddrW  = 4;
  localparam int DataW  = 32;

  localparam logic [LevelW-1:0] MaxLevelReset   = 6'd31;
  localparam logic [CountW-1:0] BarPeriodReset  = 8'd2;
  localparam logic [CountW-1:0] PeakPeriodReset = 8'd7;
  localparam logic [ColorW-1:0] PeakColorReset  = 32'h00FF00FF;
  localparam logic [RowW-1:0]   LevelReset      = 7'd32;

  typedef enum logic {
    CMD_BAR   = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MAX_LEVEL   = 2'd0,
    REG_BAR_PERIOD  = 2'd1,
    REG_PEAK_PERIOD = 2'd2,
    REG_PEAK_COLOR  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [LevelW-1:0] max_level;
    logic [CountW-1:0] bar_period;
    logic [CountW-1:0] peak_period;
    logic [ColorW-1:0] peak_color;
  } cfg_t;

  typedef struct packed {
    logic [RowW-1:0]   bar_level;
    logic [CountW-1:0] bar_count;
    logic [RowW-1:0]   peak_level;
    logic [CountW-1:0] peak_count;
  } col_state_t;

  typedef struct packed {
    cmd_e            command;
    logic [RowW-1:0] row;
    logic            paint;
  } slot_t;

  typedef struct packed {
    slot_t [2:0]     slots;
    logic [1:0]      count;
    logic [ColW-1:0] column;
  } plan_t;

endpackage

`default_nettype wire

[sv/sbpm_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbpm_cfg
  import sbpm_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;
  reg_e sel;
  logic wr_en;

  assign sel   = reg_e'(paddr[3:2]);
  assign wr_en = psel & penable & pwrite;
  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_level   <= MaxLevelReset;
      cfg_q.bar_period  <= BarPeriodReset;
      cfg_q.peak_period <= PeakPeriodReset;
      cfg_q.peak_color  <= PeakColorReset;
    end else if (wr_en) begin
      case (sel)
        REG_MAX_LEVEL:   cfg_q.max_level   <= pwdata[LevelW-1:0];
        REG_BAR_PERIOD:  cfg_q.bar_period  <= pwdata[CountW-1:0];
        REG_PEAK_PERIOD: cfg_q.peak_period <= pwdata[CountW-1:0];
        REG_PEAK_COLOR:  cfg_q.peak_color  <= pwdata[ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_MAX_LEVEL:   prdata = DataW'(cfg_q.max_level);
      REG_BAR_PERIOD:  prdata = DataW'(cfg_q.bar_period);
      REG_PEAK_PERIOD: prdata = DataW'(cfg_q.peak_period);
      REG_PEAK_COLOR:  prdata = DataW'(cfg_q.peak_color);
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/sbpm_update.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbpm_update
  import sbpm_pkg::*;
#(
  parameter int COLUMNS = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire cfg_t            cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [ColW-1:0] column_i,
  input  wire logic [MagW-1:0] magnitude_i,
  output logic                 plan_valid_o,
  input  wire logic            plan_ready_i,
  output plan_t                plan_o
);

  localparam int IdxW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  col_state_t        mem_q [COLUMNS];
  logic              vld_q [COLUMNS];
  col_state_t        rd_q;
  logic              rd_vld_q;
  logic              s1_valid_q;
  logic [ColW-1:0]   s1_col_q;
  logic [LevelW-1:0] s1_level_q;
  logic              fwd_valid_q;
  logic [IdxW-1:0]   fwd_idx_q;
  col_state_t        fwd_st_q;

  logic              accept;
  logic              in_range;
  logic [IdxW-1:0]   in_idx;
  logic [IdxW-1:0]   s1_idx;
  logic [LevelW-1:0] level_d;
  logic              s1_move;
  col_state_t        cur;
  col_state_t        nxt;
  logic [RowW-1:0]   lvl;
  logic [RowW-1:0]   lvl_up;
  logic              bar_hit;
  logic              bar_fire;
  logic              peak_hit;
  logic              peak_fire;
  logic [CountW-1:0] bc_inc;
  logic [CountW-1:0] pc_inc;
  logic              bar_any;
  logic              peak_any;
  slot_t             bar_slot;
  slot_t             erase_slot;
  slot_t             draw_slot;

  assign accept   = in_valid_i & in_ready_o;
  assign in_range = int'(column_i) < COLUMNS;
  assign in_idx   = IdxW'(column_i);
  assign s1_idx   = IdxW'(s1_col_q);
  assign level_d  = (magnitude_i > MagW'(cfg_i.max_level)) ? cfg_i.max_level
                                                            : magnitude_i[LevelW-1:0];

  always_comb begin
    if (fwd_valid_q && (fwd_idx_q == s1_idx)) begin
      cur = fwd_st_q;
    end else if (rd_vld_q) begin
      cur = rd_q;
    end else begin
      cur.bar_level  = LevelReset;
      cur.bar_count  = '0;
      cur.peak_level = LevelReset;
      cur.peak_count = '0;
    end
  end

  assign lvl       = RowW'(s1_level_q);
  assign lvl_up    = lvl + 7'd1;
  assign bar_hit   = lvl >= cur.bar_level;
  assign bc_inc    = cur.bar_count + 8'd1;
  assign bar_fire  = !bar_hit && (bc_inc >= cfg_i.bar_period);
  assign peak_hit  = cur.peak_level <= lvl_up;
  assign pc_inc    = cur.peak_count + 8'd1;
  assign peak_fire = !peak_hit && (pc_inc >= cfg_i.peak_period);
  assign bar_any   = bar_hit | bar_fire;
  assign peak_any  = peak_hit | peak_fire;

  always_comb begin
    nxt = cur;
    if (bar_hit) begin
      nxt.bar_level = lvl;
    end else begin
      nxt.bar_count = bar_fire ? '0 : bc_inc;
      if (bar_fire && (cur.bar_level != '0)) begin
        nxt.bar_level = cur.bar_level - 7'd1;
      end
    end
    if (peak_hit) begin
      nxt.peak_level = lvl_up;
    end else begin
      nxt.peak_count = peak_fire ? '0 : pc_inc;
      if (peak_fire && (cur.peak_level != '0)) begin
        nxt.peak_level = cur.peak_level - 7'd1;
      end
    end
  end

  always_comb begin
    bar_slot.command   = bar_hit ? CMD_BAR : CMD_PIXEL;
    bar_slot.row       = bar_hit ? lvl : cur.bar_level;
    bar_slot.paint     = 1'b0;
    erase_slot.command = CMD_PIXEL;
    erase_slot.row     = cur.peak_level;
    erase_slot.paint   = 1'b0;
    draw_slot.command  = CMD_PIXEL;
    draw_slot.row      = nxt.peak_level;
    draw_slot.paint    = 1'b1;
    plan_o.column      = s1_col_q;
    plan_o.count       = {peak_any, bar_any ^ 1'b0} + {1'b0, peak_any & 1'b0};
    if (bar_any) begin
      plan_o.slots = {draw_slot, erase_slot, bar_slot};
    end else begin
      plan_o.slots = {draw_slot, draw_slot, erase_slot};
    end
  end

  assign plan_valid_o = s1_valid_q & (plan_o.count != 2'd0);
  assign s1_move      = s1_valid_q & (plan_ready_i | (plan_o.count == 2'd0));
  assign in_ready_o   = !s1_valid_q | s1_move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= accept & in_range;
      end
      if (s1_move) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q   <= column_i;
      s1_level_q <= level_d;
      rd_q       <= mem_q[in_idx];
    end
    if (s1_move) begin
      mem_q[s1_idx] <= nxt;
      fwd_idx_q     <= s1_idx;
      fwd_st_q      <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COLUMNS; i++) begin
        vld_q[i] <= 1'b0;
      end
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= vld_q[in_idx];
      end
      if (s1_move) begin
        vld_q[s1_idx] <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/sbpm_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbpm_emit
  import sbpm_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [ColorW-1:0] peak_color_i,
  input  wire logic              plan_valid_i,
  output logic                   plan_ready_o,
  input  wire plan_t             plan_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cmd_e                   out_command_o,
  output logic      [ColW-1:0]   out_column_o,
  output logic      [RowW-1:0]   out_row_o,
  output logic      [ColorW-1:0] out_color_o,
  output logic                   out_last_o
);

  logic            p_valid_q;
  plan_t           plan_q;
  logic [1:0]      k_q;
  logic            o_valid_q;
  cmd_e            o_cmd_q;
  logic [ColW-1:0] o_col_q;
  logic [RowW-1:0] o_row_q;
  logic            o_paint_q;
  logic            o_last_q;

  logic            o_load;
  logic            is_last;
  logic            p_done;
  slot_t           cur_slot;

  always_comb begin
    case (k_q)
      2'd0:    cur_slot = plan_q.slots[0];
      2'd1:    cur_slot = plan_q.slots[1];
      default: cur_slot = plan_q.slots[2];
    endcase
  end

  assign o_load       = p_valid_q & (!o_valid_q | out_ready_i);
  assign is_last      = k_q == (plan_q.count - 2'd1);
  assign p_done       = o_load & is_last;
  assign plan_ready_o = !p_valid_q | p_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      k_q       <= '0;
      o_valid_q <= 1'b0;
    end else begin
      if (plan_ready_o) begin
        p_valid_q <= plan_valid_i;
      end
      if (o_load) begin
        k_q <= is_last ? 2'd0 : k_q + 2'd1;
      end
      if (o_load) begin
        o_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (plan_ready_o && plan_valid_i) begin
      plan_q <= plan_i;
    end
    if (o_load) begin
      o_cmd_q   <= cur_slot.command;
      o_col_q   <= plan_q.column;
      o_row_q   <= cur_slot.row;
      o_paint_q <= cur_slot.paint;
      o_last_q  <= is_last;
    end
  end

  assign out_valid_o   = o_valid_q;
  assign out_command_o = o_cmd_q;
  assign out_column_o  = o_col_q;
  assign out_row_o     = o_row_q;
  assign out_color_o   = o_paint_q ? peak_color_i : '0;
  assign out_last_o    = o_last_q;

endmodule

`default_nettype wire

[sv/spectrum_bar_peak_meter_top.sv]
// Spectrum bar meter with a falling peak marker per display column.
// The slave stream takes one transfer per column: a column index and a
// magnitude. For each transfer the block sends zero to three draw commands
// on the master stream: a bar draw or top-pixel erase, then a marker erase
// and a marker draw. tlast marks the final command of one input transfer.
// Registers sit on an APB port at byte addresses 0, 4, 8 and 12. The user
// must write them only while the block is idle; it does not enforce this.
// The first command of an input passes the update stage and the plan
// register before it loads the output register. The output command
// sequencer sends the commands of one input in turn and takes the next
// plan as it loads the last one. Column state lives in one memory that is
// read on input, written one stage later, with the newest write forwarded.
// After reset every column holds bar and marker at row 32 with cleared
// counters; per-column valid bits give this at once, with no clearing pass.
// A stalled master side holds the output register and backs up the stages,
// so no transfer is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_bar_peak_meter_top
  import sbpm_pkg::*;
#(
  parameter int COLUMNS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] column, [13:6] magnitude, [15:14] zero.
  input  wire logic [15:0]      s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // [5:0] draw_column, [12:6] row, [44:13] color, [47:45] zero.
  output logic      [47:0]      m_axis_tdata,
  // [0] command.
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);

  cfg_t            cfg;
  logic            plan_valid;
  logic            plan_ready;
  plan_t           plan;
  cmd_e            out_cmd;
  logic [ColW-1:0] out_col;
  logic [RowW-1:0] out_row;
  logic [ColorW-1:0] out_color;

  assign pready = 1'b1;

  sbpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg_o   (cfg)
  );

  sbpm_update #(
    .COLUMNS (COLUMNS)
  ) u_update (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .column_i     (s_axis_tdata[5:0]),
    .magnitude_i  (s_axis_tdata[13:6]),
    .plan_valid_o (plan_valid),
    .plan_ready_i (plan_ready),
    .plan_o       (plan)
  );

  sbpm_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .peak_color_i  (cfg.peak_color),
    .plan_valid_i  (plan_valid),
    .plan_ready_o  (plan_ready),
    .plan_i        (plan),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_command_o (out_cmd),
    .out_column_o  (out_col),
    .out_row_o     (out_row),
    .out_color_o   (out_color),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, out_color, out_row, out_col};
  assign m_axis_tuser = out_cmd;

endmodule

`default_nettype wire
